>>> sv/stft_ola_pkg.sv
// Shared constants, types and twiddle-table generation for the STFT overlap-add filter.
// No dependencies; imported by stft_overlap_add_filter_core and its testbench.
package stft_ola_pkg;

  localparam int N      = 512;
  localparam int LOG_N  = 9;
  localparam int HALF_N = N / 2;
  localparam int QN     = N / 4;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  localparam logic REG_OVERLAP    = 1'b0;
  localparam logic REG_COMPLEMENT = 1'b1;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  localparam longint unsigned COS_DIV [1:6] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132};
  localparam longint unsigned SIN_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  typedef logic [LOG_N-1:0] idx_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  typedef logic [15:0] qcos_t [0:QN];

  // Q30 Taylor series on one octant; cosine when odd is 0, sine otherwise
  function automatic longint taylor(longint unsigned x, logic odd);
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    x2  = (x * x) >> 30;
    t   = odd ? x : ONE_Q30;
    sum = longint'(t);
    for (int i = 1; i <= 6; i++) begin
      if (odd) t = ((t * x2) >> 30) / SIN_DIV[i];
      else     t = ((t * x2) >> 30) / COS_DIV[i];
      if (i[0]) sum = sum - longint'(t);
      else      sum = sum + longint'(t);
    end
    return sum;
  endfunction

  function automatic qcos_t gen_qcos();
    qcos_t           tab;
    longint          v;
    longint unsigned x;
    for (int m = 0; m <= QN; m++) begin
      if (8 * m <= N) begin
        x = (2 * PI_Q30 * longint'(m)) / N;
        v = taylor(x, 1'b0);
      end else begin
        x = (2 * PI_Q30 * longint'(QN - m)) / N;
        v = taylor(x, 1'b1);
      end
      if (v < 0) v = 0;
      tab[m] = 16'((v + 16384) >>> 15);
    end
    return tab;
  endfunction

  localparam qcos_t QCOS = gen_qcos();

  // cos(2*pi*k/N) in Q15 from the quarter-wave table
  function automatic logic signed [17:0] full_cos(idx_t k);
    idx_t m;
    logic neg;
    logic signed [17:0] v;
    if (k <= idx_t'(QN)) begin
      m = k; neg = 1'b0;
    end else if (k <= idx_t'(2 * QN)) begin
      m = idx_t'(2 * QN) - k; neg = 1'b1;
    end else if (k <= idx_t'(3 * QN)) begin
      m = k - idx_t'(2 * QN); neg = 1'b1;
    end else begin
      m = idx_t'(0) - k; neg = 1'b0;
    end
    v = signed'({2'b00, QCOS[m[LOG_N-2:0]]});
    return neg ? -v : v;
  endfunction

  function automatic idx_t bit_rev(idx_t i);
    idx_t r;
    for (int b = 0; b < LOG_N; b++) r[b] = i[LOG_N-1-b];
    return r;
  endfunction

endpackage

>>> sv/stft_overlap_add_filter_core.sv
// Overlap-add frequency-domain filter: sequencer, shared multiplier and on-chip memories.
// Depends on stft_ola_pkg for constants, twiddle table and index helpers.
//
// A load word or a sample word that completes no frame is taken and the block stays idle. A
// sample word that completes a frame keeps the block busy until its hop of output words (hop =
// 512 >> shift, 1 to 64) has left: one 32x18 multiplier is shared by the windowing, both
// 512-point FFTs (2304 butterflies each) and the gain pass, which with the bit-reverse pass all
// work on a single work memory. Output words then follow one at a time while the consumer is
// ready. After reset a clearing pass zeroes the accumulator and sets the gain table to unity; no
// input word is taken during it.
module stft_overlap_add_filter_core
  import stft_ola_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [15:0] sample_in,
  input  logic [8:0]         gain_index,
  input  logic [15:0]        gain_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               last
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_LD_RD, S_LD_MUL, S_LD_WR,
    S_BF_RB, S_BF_RA, S_BF_M1, S_BF_M2, S_BF_M3, S_BF_M4, S_BF_M5, S_BF_WA, S_BF_WB,
    S_GN_RD, S_GN_M1, S_GN_M2, S_GN_WR,
    S_SW_RI, S_SW_RR, S_SW_WI, S_SW_WR,
    S_AC_RD, S_AC_WR,
    S_OUT_RD, S_OUT_SHOW, S_OUT_WAIT
  } state_t;

  state_t state;

  logic [3:0] ovs;
  logic       comp;
  idx_t       wptr, abase, cnt;
  logic [9:0] filled, stride;
  logic [3:0] fs;
  logic [6:0] hop;
  logic [3:0] stage;
  logic [7:0] bcnt;
  logic       inv;
  cplx_t      adat, bdat;
  logic signed [17:0] cw, sw, wreg, gsel;
  logic signed [49:0] prod, sum;
  logic signed [35:0] tr, ti;
  logic signed [31:0] gre;

  // memories
  cplx_t              fmem [0:N-1];
  logic signed [15:0] hmem [0:N-1];
  logic signed [23:0] amem [0:N-1];
  logic [15:0]        gmem [0:HALF_N];
  cplx_t              fdata;
  logic signed [15:0] hdata;
  logic signed [23:0] adata;
  logic [15:0]        gdata;

  logic        f_we, a_we, g_we, h_we;
  idx_t        f_raddr, f_waddr, a_raddr, a_waddr, g_raddr, g_waddr, h_raddr;
  cplx_t       f_wdata;
  logic signed [23:0] a_wdata;
  logic [15:0] g_wdata;

  logic signed [31:0] mul_x;
  logic signed [17:0] mul_y;

  function automatic logic signed [31:0] sat32(logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] bf_out(logic signed [31:0] a,
                                                logic signed [35:0] t,
                                                logic sub, logic dv);
    logic signed [36:0] av;
    logic signed [36:0] tv;
    logic signed [36:0] v;
    logic signed [49:0] w;
    av = a;
    tv = t;
    v  = sub ? av - tv : av + tv;
    if (dv) v = (v + 37'sd1) >>> 1;
    w = v;
    return sat32(w);
  endfunction

  // effective overlap shift and hop
  logic [3:0] s_eff;
  logic [6:0] hop_eff;
  always_comb begin
    if (ovs < 4'd3)      s_eff = 4'd3;
    else if (ovs > 4'd9) s_eff = 4'd9;
    else                 s_eff = ovs;
    hop_eff = 7'(10'd512 >> s_eff);
  end

  // butterfly addressing
  idx_t bf_mask, bf_j, bf_a, bf_b, bf_k, bf_ks;
  always_comb begin
    bf_mask = (9'd1 << stage) - 9'd1;
    bf_j    = {1'b0, bcnt} & bf_mask;
    bf_a    = ((({1'b0, bcnt}) >> stage) << (stage + 4'd1)) | bf_j;
    bf_b    = bf_a | (9'd1 << stage);
    bf_k    = bf_j << (4'd8 - stage);
    bf_ks   = bf_k + idx_t'(3 * QN);
  end

  idx_t cnt_rev, bin;
  assign cnt_rev = bit_rev(cnt);
  assign bin     = (cnt <= idx_t'(HALF_N)) ? cnt : idx_t'(0) - cnt;

  // rounding paths
  logic signed [50:0] dsub, dadd, dsub_r, dadd_r;
  assign dsub   = sum - prod;
  assign dadd   = sum + prod;
  assign dsub_r = (dsub + 51'sd16384) >>> 15;
  assign dadd_r = (dadd + 51'sd16384) >>> 15;

  logic [4:0] ksh;
  logic signed [49:0] ld_r, gn_r;
  assign ksh  = {1'b0, fs} + 5'd7;
  assign ld_r = (prod + (50'sd1 <<< (ksh - 5'd1))) >>> ksh;
  assign gn_r = (prod + 50'sd2048) >>> 12;

  logic signed [17:0] g_now;
  assign g_now = comp ? 18'sd4096 - signed'({2'b00, gdata}) : signed'({2'b00, gdata});

  logic signed [32:0] re_x, re_r;
  logic signed [33:0] acc_s;
  logic signed [23:0] acc_sat;
  assign re_x = fdata.re;
  assign re_r = (re_x + 33'sd8) >>> 4;
  assign acc_s = adata + re_r;
  assign acc_sat = (acc_s > 34'sd8388607) ? 24'sh7FFFFF :
                   (acc_s < -34'sd8388608) ? 24'sh800000 : acc_s[23:0];

  logic signed [24:0] o_x, o_r;
  logic signed [15:0] o_sat;
  assign o_x   = adata;
  assign o_r   = (o_x + 25'sd8) >>> 4;
  assign o_sat = (o_r > 25'sd32767) ? 16'sh7FFF : (o_r < -25'sd32768) ? 16'sh8000 : o_r[15:0];

  // datapath selection
  always_comb begin
    f_we = 1'b0; f_waddr = cnt; f_wdata = fdata; f_raddr = cnt;
    a_we = 1'b0; a_waddr = abase + cnt; a_wdata = acc_sat; a_raddr = abase + cnt;
    g_we = 1'b0; g_waddr = cnt; g_wdata = 16'd4096; g_raddr = bin;
    h_we = 1'b0; h_raddr = wptr + cnt;
    mul_x = bdat.re; mul_y = cw;
    unique case (state)
      S_CLEAR: begin
        a_we = 1'b1; a_waddr = cnt; a_wdata = '0;
        g_we = (cnt <= idx_t'(HALF_N));
      end
      S_IDLE: begin
        h_we = in_valid && (action == ACT_SAMPLE);
        g_we = in_valid && (action == ACT_LOAD) && (gain_index <= 9'(HALF_N));
        g_waddr = gain_index; g_wdata = gain_value;
      end
      S_LD_MUL: begin mul_x = hdata; mul_y = wreg; end
      S_LD_WR: begin
        f_we = 1'b1; f_waddr = cnt_rev;
        f_wdata.re = sat32(ld_r); f_wdata.im = '0;
      end
      S_BF_RB: f_raddr = bf_b;
      S_BF_RA: f_raddr = bf_a;
      S_BF_M1: begin mul_x = bdat.re; mul_y = cw; end
      S_BF_M2: begin mul_x = bdat.im; mul_y = sw; end
      S_BF_M3: begin mul_x = bdat.re; mul_y = sw; end
      S_BF_M4: begin mul_x = bdat.im; mul_y = cw; end
      S_BF_WA: begin
        f_we = 1'b1; f_waddr = bf_a;
        f_wdata.re = bf_out(adat.re, tr, 1'b0, inv);
        f_wdata.im = bf_out(adat.im, ti, 1'b0, inv);
      end
      S_BF_WB: begin
        f_we = 1'b1; f_waddr = bf_b;
        f_wdata.re = bf_out(adat.re, tr, 1'b1, inv);
        f_wdata.im = bf_out(adat.im, ti, 1'b1, inv);
      end
      S_GN_M1: begin mul_x = fdata.re; mul_y = g_now; end
      S_GN_M2: begin mul_x = adat.im; mul_y = gsel; end
      S_GN_WR: begin
        f_we = 1'b1; f_wdata.re = gre; f_wdata.im = sat32(gn_r);
      end
      S_SW_RR: f_raddr = cnt_rev;
      S_SW_WI: f_we = 1'b1;
      S_SW_WR: begin f_we = 1'b1; f_waddr = cnt_rev; f_wdata = adat; end
      S_AC_WR: a_we = 1'b1;
      S_OUT_SHOW: begin a_we = 1'b1; a_wdata = '0; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_waddr] <= f_wdata;
    fdata <= fmem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hmem[wptr] <= sample_in;
    hdata <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_waddr] <= a_wdata;
    adata <= amem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    gdata <= gmem[g_raddr];
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_OVERLAP:    prdata = {28'd0, ovs};
      REG_COMPLEMENT: prdata = {31'd0, comp};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovs  <= 4'd3;
      comp <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_OVERLAP:    ovs  <= pwdata[3:0];
        REG_COMPLEMENT: comp <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      wptr      <= '0;
      abase     <= '0;
      filled    <= '0;
      stride    <= '0;
      stage     <= '0;
      bcnt      <= '0;
      inv       <= 1'b0;
      out_valid <= 1'b0;
      last      <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 9'd1;
          if (cnt == idx_t'(N - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && action == ACT_SAMPLE) begin
            wptr <= wptr + 9'd1;
            fs   <= s_eff;
            hop  <= hop_eff;
            cnt  <= '0;
            if (filled != 10'(N)) begin
              filled <= filled + 10'd1;
              if (filled == 10'(N - 1)) begin
                stride <= '0;
                state  <= S_LD_RD;
              end
            end else if (stride + 10'd1 >= {3'd0, hop_eff}) begin
              stride <= '0;
              state  <= S_LD_RD;
            end else begin
              stride <= stride + 10'd1;
            end
          end
        end
        S_LD_RD: begin
          wreg  <= 18'sd32768 - full_cos(cnt);
          state <= S_LD_MUL;
        end
        S_LD_MUL: state <= S_LD_WR;
        S_LD_WR: begin
          cnt <= cnt + 9'd1;
          if (cnt == idx_t'(N - 1)) begin
            stage <= '0; bcnt <= '0; inv <= 1'b0;
            state <= S_BF_RB;
          end else begin
            state <= S_LD_RD;
          end
        end
        S_BF_RB: begin
          cw    <= full_cos(bf_k);
          sw    <= inv ? full_cos(bf_ks) : -full_cos(bf_ks);
          state <= S_BF_RA;
        end
        S_BF_RA: begin bdat <= fdata; state <= S_BF_M1; end
        S_BF_M1: begin adat <= fdata; state <= S_BF_M2; end
        S_BF_M2: begin sum <= prod; state <= S_BF_M3; end
        S_BF_M3: begin tr <= dsub_r[35:0]; state <= S_BF_M4; end
        S_BF_M4: begin sum <= prod; state <= S_BF_M5; end
        S_BF_M5: begin ti <= dadd_r[35:0]; state <= S_BF_WA; end
        S_BF_WA: state <= S_BF_WB;
        S_BF_WB: begin
          bcnt <= bcnt + 8'd1;
          if (bcnt == 8'hFF) begin
            if (stage == 4'(LOG_N - 1)) begin
              stage <= '0;
              cnt   <= '0;
              state <= inv ? S_AC_RD : S_GN_RD;
            end else begin
              stage <= stage + 4'd1;
              state <= S_BF_RB;
            end
          end else begin
            state <= S_BF_RB;
          end
        end
        S_GN_RD: state <= S_GN_M1;
        S_GN_M1: begin adat <= fdata; gsel <= g_now; state <= S_GN_M2; end
        S_GN_M2: begin gre <= sat32(gn_r); state <= S_GN_WR; end
        S_GN_WR: begin
          cnt <= cnt + 9'd1;
          state <= (cnt == idx_t'(N - 1)) ? S_SW_RI : S_GN_RD;
        end
        S_SW_RI: begin
          if (cnt < cnt_rev) begin
            state <= S_SW_RR;
          end else if (cnt == idx_t'(N - 1)) begin
            stage <= '0; bcnt <= '0; inv <= 1'b1;
            state <= S_BF_RB;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        S_SW_RR: begin adat <= fdata; state <= S_SW_WI; end
        S_SW_WI: state <= S_SW_WR;
        S_SW_WR: begin cnt <= cnt + 9'd1; state <= S_SW_RI; end
        S_AC_RD: state <= S_AC_WR;
        S_AC_WR: begin
          cnt <= cnt + 9'd1;
          state <= (cnt == idx_t'(N - 1)) ? S_OUT_RD : S_AC_RD;
        end
        S_OUT_RD: state <= S_OUT_SHOW;
        S_OUT_SHOW: begin
          sample_out <= o_sat;
          last       <= ({2'b00, hop} == cnt + 9'd1);
          out_valid  <= 1'b1;
          state      <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              abase <= abase + {2'b00, hop};
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + 9'd1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result words only leave from the output hold state
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT_WAIT)
    else $error("out_valid outside output state");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  a_fill_stride: assert property (@(posedge clk) disable iff (rst)
    filled != 10'(N) |-> stride == 10'd0)
    else $error("stride counting before history is full");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_WAIT && out_ready && last) |=> state == S_IDLE)
    else $error("hop run did not return to idle");

  a_stride_bound: assert property (@(posedge clk) disable iff (rst)
    stride < 10'd64)
    else $error("stride count out of range");

endmodule

>>> tb/tb_stft_overlap_add_filter_core.sv
// Self-checking testbench for stft_overlap_add_filter_core: directed and random words,
// register phases over APB, scoreboard against an in-bench fixed-point predictor.
// Depends on stft_ola_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_stft_overlap_add_filter_core;
  import stft_ola_pkg::*;

  localparam int  NW        = 512;
  localparam int  FFT_LAT   = 64;
  localparam longint PI30   = 64'd3373259426;
  localparam longint ONE30  = 64'd1073741824;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid, in_ready;
  logic               action;
  logic signed [15:0] sample_in;
  logic [8:0]         gain_index;
  logic [15:0]        gain_value;
  logic               out_valid, out_ready;
  logic signed [15:0] sample_out;
  logic               last;

  stft_overlap_add_filter_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .sample_in(sample_in),
    .gain_index(gain_index), .gain_value(gain_value),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out), .last(last)
  );

  typedef struct {
    logic signed [15:0] smp;
    logic               lst;
  } out_word_t;

  typedef struct {
    logic        act;
    logic [15:0] smp;
    logic [8:0]  gidx;
    logic [15:0] gval;
  } stim_row_t;

  // filter state mirror
  longint  cos_q15 [NW];
  longint  sin_q15 [NW/2];
  longint  hist    [NW];
  longint  acc     [NW];
  longint  wre     [NW];
  longint  wim     [NW];
  int      gain_tab[NW/2+1];
  int      stride_cnt, fill_cnt;
  int      ovl_shift, cmpl_gain;

  out_word_t filt_q[$];
  int        n_err;
  int        n_got;
  int        n_samples;
  int        burst_left;
  bit        hold_done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[stft_overlap_add_filter_core] ERROR");
    $finish;
  end

  function automatic longint rnd_shr(longint v, int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clip(longint v, int bits);
    longint lim;
    lim = 64'sd1 <<< (bits - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // octant series in Q30; sine terms when want_sin, else cosine
  function automatic longint octant_series(longint unsigned x, bit want_sin);
    longint unsigned xx, term, dv;
    longint          total;
    xx    = (x * x) >> 30;
    term  = want_sin ? x : ONE30;
    total = longint'(term);
    for (int n = 1; n <= 6; n++) begin
      dv    = want_sin ? longint'(2 * n * (2 * n + 1)) : longint'((2 * n - 1) * 2 * n);
      term  = ((term * xx) >> 30) / dv;
      total = n[0] ? total - longint'(term) : total + longint'(term);
    end
    return total;
  endfunction

  function automatic void build_trig();
    longint qc [NW/4+1];
    longint v;
    int     q;
    q = NW / 4;
    for (int m = 0; m <= q; m++) begin
      if (8 * m <= NW) v = octant_series((2 * PI30 * m) / NW, 1'b0);
      else             v = octant_series((2 * PI30 * (q - m)) / NW, 1'b1);
      if (v < 0) v = 0;
      qc[m] = (v + 16384) >>> 15;
    end
    for (int k = 0; k < NW; k++) begin
      if (k <= q)          cos_q15[k] = qc[k];
      else if (k <= 2 * q) cos_q15[k] = -qc[2 * q - k];
      else if (k <= 3 * q) cos_q15[k] = -qc[k - 2 * q];
      else                 cos_q15[k] = qc[NW - k];
    end
    for (int k = 0; k < NW / 2; k++) sin_q15[k] = cos_q15[(k + 3 * q) % NW];
  endfunction

  function automatic int rev9(int i);
    int r;
    r = 0;
    for (int b = 0; b < 9; b++) r = (r << 1) | ((i >> b) & 1);
    return r;
  endfunction

  function automatic int shift_now();
    int s;
    s = ovl_shift;
    if (s < 3) s = 3;
    if (s > 9) s = 9;
    return s;
  endfunction

  function automatic void fft_pass(bit inv);
    longint c, sn, tr, ti, pr, pim, mr, mi;
    int     half, step, a, b;
    for (int len = 2; len <= NW; len = len * 2) begin
      half = len / 2;
      step = NW / len;
      for (int base = 0; base < NW; base += len) begin
        for (int j = 0; j < half; j++) begin
          c  = cos_q15[j * step];
          sn = inv ? sin_q15[j * step] : -sin_q15[j * step];
          a  = base + j;
          b  = a + half;
          tr = rnd_shr(wre[b] * c - wim[b] * sn, 15);
          ti = rnd_shr(wre[b] * sn + wim[b] * c, 15);
          pr = wre[a] + tr; pim = wim[a] + ti;
          mr = wre[a] - tr; mi = wim[a] - ti;
          if (inv) begin
            pr = rnd_shr(pr, 1); pim = rnd_shr(pim, 1);
            mr = rnd_shr(mr, 1); mi = rnd_shr(mi, 1);
          end
          wre[a] = clip(pr, 32); wim[a] = clip(pim, 32);
          wre[b] = clip(mr, 32); wim[b] = clip(mi, 32);
        end
      end
    end
  endfunction

  function automatic void filter_frame(int s);
    longint g, t;
    int     r, bin;
    for (int i = 0; i < NW; i++) begin
      r = rev9(i);
      wre[r] = clip(rnd_shr(hist[i] * (32768 - cos_q15[i]), 7 + s), 32);
      wim[r] = 0;
    end
    fft_pass(1'b0);
    for (int i = 0; i < NW; i++) begin
      bin = (i <= NW / 2) ? i : NW - i;
      g   = gain_tab[bin];
      if (cmpl_gain != 0) g = 4096 - g;
      wre[i] = clip(rnd_shr(wre[i] * g, 12), 32);
      wim[i] = clip(rnd_shr(wim[i] * g, 12), 32);
    end
    for (int i = 0; i < NW; i++) begin
      r = rev9(i);
      if (i < r) begin
        t = wre[i]; wre[i] = wre[r]; wre[r] = t;
        t = wim[i]; wim[i] = wim[r]; wim[r] = t;
      end
    end
    fft_pass(1'b1);
    for (int i = 0; i < NW; i++) acc[i] = clip(acc[i] + rnd_shr(wre[i], 4), 24);
  endfunction

  // advance the mirror by one accepted word, queue the finished samples it releases
  function automatic void predict_word(stim_row_t w);
    int        s, hop;
    bit        fire;
    out_word_t o;
    if (w.act == ACT_LOAD) begin
      if (w.gidx <= NW / 2) gain_tab[w.gidx] = w.gval;
      return;
    end
    for (int i = 0; i < NW - 1; i++) hist[i] = hist[i + 1];
    hist[NW - 1] = longint'($signed(w.smp));
    s    = shift_now();
    hop  = NW >> s;
    fire = 1'b0;
    if (fill_cnt < NW) begin
      fill_cnt++;
      if (fill_cnt == NW) begin
        fire = 1'b1; stride_cnt = 0;
      end
    end else begin
      stride_cnt++;
      if (stride_cnt >= hop) begin
        fire = 1'b1; stride_cnt = 0;
      end
    end
    if (!fire) return;
    filter_frame(s);
    for (int i = 0; i < hop; i++) begin
      o.smp = 16'(clip(rnd_shr(acc[i], 4), 16));
      o.lst = (i + 1 == hop);
      filt_q.push_back(o);
    end
    for (int i = 0; i < NW; i++) acc[i] = (i + hop < NW) ? acc[i + hop] : 0;
  endfunction

  task automatic send_word(stim_row_t w);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 20);
      burst_left = $urandom_range(1, 30);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= w.act;
    sample_in  <= w.smp;
    gain_index <= w.gidx;
    gain_value <= w.gval;
    do @(posedge clk); while (!in_ready);
    predict_word(w);
    if (w.act == ACT_SAMPLE) n_samples++;
  endtask

  function automatic stim_row_t rand_word();
    stim_row_t w;
    w.act  = ($urandom_range(0, 9) == 0) ? ACT_LOAD : ACT_SAMPLE;
    w.smp  = 16'($urandom);
    w.gidx = 9'($urandom);
    w.gval = 16'($urandom);
    if (w.act == ACT_SAMPLE) begin
      case ($urandom_range(0, 3))
        0: w.smp = 16'($signed($urandom_range(0, 4096)) - 2048);
        1: w.smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: ;
      endcase
    end else begin
      if ($urandom_range(0, 7) != 0) w.gidx = 9'($urandom_range(0, NW / 2));
      if ($urandom_range(0, 7) != 0) w.gval = 16'($urandom_range(0, 8192));
    end
    return w;
  endfunction

  task automatic send_samples(int n_target);
    while (n_samples < n_target) send_word(rand_word());
  endtask

  task automatic write_reg(logic which, int val);
    @(negedge clk);
    in_valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
    repeat (FFT_LAT) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {which, 2'b00}; pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (which == REG_OVERLAP) ovl_shift = val & 15;
    else                      cmpl_gain = val & 1;
  endtask

  // scoreboard
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_got++;
      if (filt_q.size() == 0) begin
        $error("unexpected word: sample_out %0d last %0b", sample_out, last);
        n_err++;
      end else begin
        if (sample_out !== filt_q[0].smp) begin
          $error("sample_out: expected %0d, got %0d", filt_q[0].smp, sample_out);
          n_err++;
        end
        if (last !== filt_q[0].lst) begin
          $error("last: expected %0b, got %0b", filt_q[0].lst, last);
          n_err++;
        end
        void'(filt_q.pop_front());
      end
    end
  end

  // consumer: runs of no, moderate and heavy back-pressure, plus one long hold-off
  initial begin
    int run_left, pct;
    out_ready = 1'b0;
    run_left  = 0;
    pct       = 100;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (!hold_done && n_got >= 20) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        case ($urandom_range(0, 2))
          0: pct = 100;
          1: pct = 50;
          default: pct = 20;
        endcase
      end
      run_left--;
      out_ready <= ($urandom_range(1, 100) <= pct);
    end
  end

  initial begin
    // directed words: none of these completes a window, so no output is expected from them
    stim_row_t dir_rows [] = '{
      '{ACT_LOAD,   16'h0000, 9'd0,     16'h0000},
      '{ACT_LOAD,   16'hFFFF, 9'd256,   16'hFFFF},
      '{ACT_LOAD,   16'h0000, 9'd257,   16'h1234},   // beyond N/2: dropped
      '{ACT_LOAD,   16'h0000, 9'h1FF,   16'hFFFF},   // dropped
      '{ACT_LOAD,   16'h5555, 9'd128,   16'h1000},
      '{ACT_LOAD,   16'h0000, 9'd1,     16'h2000},
      '{ACT_LOAD,   16'h0000, 9'd255,   16'h8000},
      '{ACT_LOAD,   16'h0000, 9'd3,     16'h0001},
      '{ACT_SAMPLE, 16'h7FFF, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'h8000, 9'h1FF,   16'hFFFF},   // gain fields ignored
      '{ACT_SAMPLE, 16'h0000, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'hFFFF, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'h0001, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'h5555, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'hAAAA, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'h7FFF, 9'd0,     16'h0000},
      '{ACT_SAMPLE, 16'h8000, 9'd0,     16'h0000}
    };
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; action = ACT_SAMPLE; sample_in = '0; gain_index = '0; gain_value = '0;
    n_err = 0; n_got = 0; n_samples = 0; burst_left = 0; hold_done = 1'b0;
    build_trig();
    for (int i = 0; i < NW; i++) begin
      hist[i] = 0; acc[i] = 0;
    end
    for (int i = 0; i <= NW / 2; i++) gain_tab[i] = 4096;
    stride_cnt = 0; fill_cnt = 0; ovl_shift = 3; cmpl_gain = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i]);
    send_samples(NW + 2 * 64);          // first window, then two hops of 64
    write_reg(REG_OVERLAP, 0);          // clamps up to 3
    write_reg(REG_COMPLEMENT, 1);
    send_samples(n_samples + 128);
    write_reg(REG_OVERLAP, 15);         // clamps down to 9: hop of one
    write_reg(REG_COMPLEMENT, 0);
    send_samples(n_samples + 3);
    write_reg(REG_OVERLAP, 9);
    write_reg(REG_COMPLEMENT, 1);
    send_samples(n_samples + 2);
    write_reg(REG_OVERLAP, 5);
    write_reg(REG_COMPLEMENT, 0);
    send_samples(n_samples + 40);       // leaves the stride count at 8
    write_reg(REG_OVERLAP, 6);          // new hop of 8 is already reached: next word fires
    send_samples(n_samples + 10);

    @(negedge clk);
    in_valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_err == 0) $display("[stft_overlap_add_filter_core] OK");
    else            $display("[stft_overlap_add_filter_core] ERROR");
    $finish;
  end

endmodule
